// ----- hw/rtl/mss_pkg.sv -----
// Shared types, codes and reset values for the motor setpoint sequencer.
`timescale 1ns / 1ps

package mss_pkg;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned EMF_W   = 15;
  localparam int unsigned CUR_W   = 13;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Soft start adds target / 2**SOFT_SHIFT per tick
  localparam int unsigned SOFT_SHIFT = 4;

  // Event codes
  localparam logic [OP_W-1:0] OP_CLICK = 2'd0;
  localparam logic [OP_W-1:0] OP_HOLD  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STAB   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STALL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TUNE_P = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TUNE_I = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BACK_EMF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_SENSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS   = 3'd4;

  // Configuration reset values
  localparam logic [EMF_W-1:0] RST_RAMP_STEP     = 15'd100;
  localparam logic [EMF_W-1:0] RST_MIN_BACK_EMF  = 15'd800;
  localparam logic [CUR_W-1:0] RST_CURRENT_LIMIT = 13'd3000;
  localparam logic             RST_CURRENT_SENSE = 1'b1;
  localparam logic [CNT_W-1:0] RST_STALL_TICKS   = 12'd100;

  typedef struct packed {
    logic [EMF_W-1:0] ramp_step;
    logic [EMF_W-1:0] min_back_emf;
    logic [CUR_W-1:0] current_limit;
    logic             current_sense_on;
    logic [CNT_W-1:0] stall_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [EMF_W-1:0] target_emf;
    logic [EMF_W-1:0] back_emf;
    logic [CUR_W-1:0] motor_current;
  } item_t;

  typedef struct packed {
    logic [EMF_W-1:0]  setpoint;
    logic [MODE_W-1:0] mode;
    logic              stall_entered;
  } res_t;

endpackage

// ----- hw/rtl/mss_if.sv -----
// Valid/ready channel interfaces for event items and results.
`timescale 1ns / 1ps

interface mss_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [mss_pkg::OP_W-1:0]  operation;
  logic [mss_pkg::EMF_W-1:0] target_emf;
  logic [mss_pkg::EMF_W-1:0] back_emf;
  logic [mss_pkg::CUR_W-1:0] motor_current;

  modport source (output valid, operation, target_emf, back_emf, motor_current,
                  input ready);
  modport sink (input valid, operation, target_emf, back_emf, motor_current,
                output ready);
endinterface

interface mss_res_if;
  logic                       valid;
  logic                       ready;
  logic [mss_pkg::EMF_W-1:0]  setpoint;
  logic [mss_pkg::MODE_W-1:0] mode;
  logic                       stall_entered;

  modport source (output valid, setpoint, mode, stall_entered, input ready);
  modport sink (input valid, setpoint, mode, stall_entered, output ready);
endinterface

// ----- hw/rtl/motor_setpoint_sequencer.sv -----
// Top level of the motor setpoint sequencer.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  cmd      | in  | valid/ready   | operation, target_emf, back_emf, motor_current
//  result   | out | valid/ready   | setpoint, mode, stall_entered
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One event per cycle sustained while result.ready holds; a result turns valid
// once its event has passed the input register, then the result register.
// The state update sits between the input register and the result register.
// A stalled result holds while one more event waits in the input register.
// Reset is synchronous and clears both stages and the mode/setpoint state.
`timescale 1ns / 1ps

module motor_setpoint_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  mss_cmd_if.sink                        cmd,
  mss_res_if.source                      result,
  input  logic                           cfg_we,
  input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mss_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  step_res;
  res_t  out_res;
  logic  out_valid;
  logic  adv;

  // The held event moves into the result register when that frees up
  assign adv       = in_valid && (!out_valid || result.ready);
  assign cmd.ready = !in_valid || adv;

  mss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_item.operation     <= cmd.operation;
      in_item.target_emf    <= cmd.target_emf;
      in_item.back_emf      <= cmd.back_emf;
      in_item.motor_current <= cmd.motor_current;
    end
  end

  mss_step u_step (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.setpoint      = out_res.setpoint;
  assign result.mode          = out_res.mode;
  assign result.stall_entered = out_res.stall_entered;

endmodule

// ----- hw/rtl/mss_cfg.sv -----
// Configuration register file, write only.
`timescale 1ns / 1ps

module mss_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mss_pkg::cfg_t                      cfg
);
  import mss_pkg::*;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step        <= RST_RAMP_STEP;
      cfg.min_back_emf     <= RST_MIN_BACK_EMF;
      cfg.current_limit    <= RST_CURRENT_LIMIT;
      cfg.current_sense_on <= RST_CURRENT_SENSE;
      cfg.stall_ticks      <= RST_STALL_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAMP_STEP:     cfg.ramp_step        <= cfg_data[EMF_W-1:0];
        CFG_MIN_BACK_EMF:  cfg.min_back_emf     <= cfg_data[EMF_W-1:0];
        CFG_CURRENT_LIMIT: cfg.current_limit    <= cfg_data[CUR_W-1:0];
        CFG_CURRENT_SENSE: cfg.current_sense_on <= cfg_data[0];
        CFG_STALL_TICKS:   cfg.stall_ticks      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/mss_step.sv -----
// Mode, setpoint and stall counter state with the per-event update logic.
`timescale 1ns / 1ps

module mss_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  mss_pkg::item_t item,
  input  mss_pkg::cfg_t  cfg,
  output mss_pkg::res_t  res
);
  import mss_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_next;
  logic [EMF_W-1:0]  setpoint;
  logic [EMF_W-1:0]  setpoint_next;
  logic [CNT_W-1:0]  stall_count;
  logic [CNT_W-1:0]  stall_count_next;
  logic              entered;

  logic [EMF_W:0]    soft_sum;
  logic [EMF_W:0]    ramp_up;
  logic [EMF_W-1:0]  over;
  logic [CNT_W-1:0]  cnt_inc;
  logic              stall_hit;

  // Arithmetic shared by the tick arms
  always_comb begin
    soft_sum = {1'b0, setpoint} + {{(SOFT_SHIFT + 1){1'b0}}, item.target_emf[EMF_W-1:SOFT_SHIFT]};
    ramp_up  = {1'b0, setpoint} + {1'b0, cfg.ramp_step};
    over     = setpoint - item.target_emf;
    cnt_inc  = stall_count + CNT_W'(1);
    stall_hit = cfg.current_sense_on ? (item.motor_current > cfg.current_limit)
                                     : (item.back_emf < cfg.min_back_emf);
  end

  // Next state for one event
  always_comb begin
    mode_next        = mode;
    setpoint_next    = setpoint;
    stall_count_next = stall_count;
    entered          = 1'b0;
    unique case (item.operation)
      OP_CLICK: begin
        if (mode == MODE_STOP) begin
          mode_next = MODE_START;
        end else if (mode != MODE_TUNE_P && mode != MODE_TUNE_I) begin
          mode_next     = MODE_STOP;
          setpoint_next = '0;
        end
      end
      OP_HOLD: begin
        unique case (mode)
          MODE_START, MODE_STAB, MODE_STALL: begin
            mode_next     = MODE_TUNE_P;
            setpoint_next = item.target_emf;
          end
          MODE_TUNE_P: mode_next = MODE_TUNE_I;
          MODE_TUNE_I: mode_next = MODE_STAB;
          default: ;
        endcase
      end
      OP_TICK: begin
        unique case (mode)
          MODE_START: begin
            if (soft_sum >= {1'b0, item.target_emf}) begin
              mode_next     = MODE_STAB;
              setpoint_next = item.target_emf;
            end else begin
              setpoint_next = soft_sum[EMF_W-1:0];
            end
          end
          MODE_STAB: begin
            // Ramp toward target, then check for stall
            if (setpoint < item.target_emf) begin
              setpoint_next = (ramp_up < {1'b0, item.target_emf}) ? ramp_up[EMF_W-1:0]
                                                                  : item.target_emf;
            end else if (setpoint > item.target_emf) begin
              setpoint_next = (over > cfg.ramp_step) ? (setpoint - cfg.ramp_step)
                                                     : item.target_emf;
            end
            if (stall_hit) begin
              mode_next        = MODE_STALL;
              setpoint_next    = '0;
              stall_count_next = '0;
              entered          = 1'b1;
            end
          end
          MODE_STALL: begin
            if (cnt_inc >= cfg.stall_ticks) begin
              mode_next        = MODE_STOP;
              stall_count_next = '0;
            end else begin
              stall_count_next = cnt_inc;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State registers, advanced once per event
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_STOP;
      setpoint    <= '0;
      stall_count <= '0;
    end else if (adv) begin
      mode        <= mode_next;
      setpoint    <= setpoint_next;
      stall_count <= stall_count_next;
    end
  end

  assign res.setpoint      = setpoint_next;
  assign res.mode          = mode_next;
  assign res.stall_entered = entered;

endmodule

// ----- hw/rtl/mss_checker.sv -----
// Port-level checks for the motor setpoint sequencer, bound to the top level.
`timescale 1ns / 1ps

module mss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [mss_pkg::EMF_W-1:0]     res_setpoint,
  input logic [mss_pkg::MODE_W-1:0]    res_mode,
  input logic                          res_stall_entered
);
  import mss_pkg::*;

  // No result may appear right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stall entry reports the stall mode with a zero setpoint
  a_stall_entry: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall_entered) |-> (res_mode == MODE_STALL && res_setpoint == '0))
    else $error("stall entry with wrong mode or setpoint");

  // Stop and stall always drive a zero setpoint
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_mode == MODE_STOP || res_mode == MODE_STALL)) |-> res_setpoint == '0)
    else $error("nonzero setpoint in stop or stall");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_setpoint) && $stable(res_mode) && $stable(res_stall_entered)))
    else $error("stalled result changed");

endmodule

bind motor_setpoint_sequencer mss_checker u_mss_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_setpoint      (result.setpoint),
  .res_mode          (result.mode),
  .res_stall_entered (result.stall_entered)
);
